FILE: src/decimal_integer_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal integer parser
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_INTEGER_PARSER_MACROS_SVH
`define DECIMAL_INTEGER_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define DIP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dip: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define DIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dip: next-cycle check failed");
`else
`define DIP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DIP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/dip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dip_pkg
// Types and constants shared by the decimal integer parser modules.
// ----------------------------------------------------------------------------
package dip_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int VALUE_W     = 64;
    localparam int CHAR_W      = 8;
    localparam int TDATA_W     = 72;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_SIGNED_MODE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_SELECT = 1'b1;

    localparam logic [1:0] WIDTH_16 = 2'd0;
    localparam logic [1:0] WIDTH_32 = 2'd1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_OVERFLOW       = 2'd1,
        ST_DIGIT_EXPECTED = 2'd2
    } status_t;

    // Classified character as it travels from front to back
    typedef struct packed {
        logic       token_start;
        logic       end_of_stream;
        logic       is_digit;
        logic       is_minus;
        logic [3:0] digit;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [VALUE_W-1:0]   value;
    } dip_out_t;

    // Back-end activity, seen by the top level
    typedef struct packed {
        logic pop;
        logic emit;
    } back_stat_t;

endpackage
`default_nettype wire

FILE: src/decimal_integer_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_integer_parser
// Parses ASCII decimal integers, one character per item, with overflow check.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one character per item in s_tdata, s_tuser marks the
//   first character of a token, s_tlast marks end of stream (character
//   ignored). Result stream m_*: value and status, at most one per item.
//   Configuration channel cfg_*: index 0 signed_mode, index 1 width_select;
//   write it only while the block is idle. cfg_ready is always high.
// Timing:
//   One item per cycle sustained while results are taken without stall.
//   A result passes through the front queue and then the back end's output
//   register before it shows on m_*. The multiply by ten, add and limit
//   compare set the clock path.
// Reset:
//   Empties the queue, drops any pending number and output, and sets the
//   configuration to unsigned, thirty-two bits.
// Stall:
//   While m_tready is low the result is held; the queue fills to its depth,
//   two items by default, then s_tready falls until the result is taken.
// ----------------------------------------------------------------------------
`include "decimal_integer_parser_macros.svh"

module decimal_integer_parser #(
    parameter int QUEUE_DEPTH = dip_pkg::QUEUE_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // [7:0] character
    input  wire logic                            s_tuser,  // [0] token_start
    input  wire logic                            s_tlast,  // end_of_stream
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [dip_pkg::TDATA_W-1:0]          m_tdata,  // [63:0] value, [65:64] status
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dip_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dip_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dip_pkg::*;

    logic        signed_mode_reg, signed_mode_next;
    logic [1:0]  width_select_reg, width_select_next;

    logic        q_full;
    logic        q_push;
    item_t       q_in;
    logic        q_valid;
    item_t       q_head;
    back_stat_t  back_stat;
    dip_out_t    result;

    // Configuration registers: always ready, take the write as it comes
    assign cfg_ready = 1'b1;

    always_comb begin
        signed_mode_next  = signed_mode_reg;
        width_select_next = width_select_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SIGNED_MODE:  signed_mode_next  = cfg_data[0];
                REG_WIDTH_SELECT: width_select_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signed_mode_reg  <= 1'b0;
            width_select_reg <= WIDTH_32;
        end else begin
            signed_mode_reg  <= signed_mode_next;
            width_select_reg <= width_select_next;
        end
    end

    // Front: accept and classify characters
    dip_front u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .character     (s_tdata),
        .token_start   (s_tuser),
        .end_of_stream (s_tlast),
        .signed_mode   (signed_mode_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_in)
    );

    // Queue: decouple the front from a stalled back end
    dip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in),
        .pop       (back_stat.pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    // Back: accumulate, check the limit, hold the result
    dip_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .signed_mode  (signed_mode_reg),
        .width_select (width_select_reg),
        .q_valid      (q_valid),
        .q_item       (q_head),
        .stat         (back_stat),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_result     (result)
    );

    // Pad the result to whole bytes
    assign m_tdata = {{(TDATA_W - $bits(dip_out_t)){1'b0}}, result};

    // An error result carries a zero value
    `DIP_ASSERT_IMPLY(a_err_value_zero, aclk, aresetn, m_tvalid && m_tdata[65:64] != ST_OK, m_tdata[63:0] == '0)
    // The back end only takes an item when its output register is free
    `DIP_ASSERT_IMPLY(a_pop_has_room, aclk, aresetn, back_stat.pop, !m_tvalid || m_tready)
    // A result written by the back end shows on the output next cycle
    `DIP_ASSERT_NEXT(a_emit_shows, aclk, aresetn, back_stat.emit, m_tvalid)

endmodule
`default_nettype wire

FILE: src/dip_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dip_front
// Accepts characters and classifies them into queue items.
// ----------------------------------------------------------------------------
module dip_front (
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [dip_pkg::CHAR_W-1:0] character,
    input  wire logic                       token_start,
    input  wire logic                       end_of_stream,
    input  wire logic                       signed_mode,
    input  wire logic                       q_full,
    output logic                            q_push,
    output dip_pkg::item_t                  q_item
);
    import dip_pkg::*;

    logic [CHAR_W-1:0] offset;

    assign s_tready = ~q_full;
    assign q_push   = s_tvalid & ~q_full;
    assign offset   = character - CHAR_ZERO;

    always_comb begin
        q_item.token_start   = token_start;
        q_item.end_of_stream = end_of_stream;
        q_item.is_digit      = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
        // a minus only counts on the first character of a signed token
        q_item.is_minus      = signed_mode && token_start && (character == CHAR_MINUS);
        q_item.digit         = offset[3:0];
    end

endmodule
`default_nettype wire

FILE: src/dip_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dip_queue
// Short register queue between front and back; push and pop in the same cycle while not full.
// ----------------------------------------------------------------------------
module dip_queue #(
    parameter int DEPTH = dip_pkg::QUEUE_DEPTH
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire dip_pkg::item_t push_item,
    input  wire logic    pop,
    output logic         full,
    output logic         valid,
    output dip_pkg::item_t head
);
    import dip_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

FILE: src/dip_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dip_back
// Runs the parse: accumulate value*10+d, check the limit, write results.
// ----------------------------------------------------------------------------
module dip_back (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     signed_mode,
    input  wire logic [1:0] width_select,
    input  wire logic     q_valid,
    input  wire dip_pkg::item_t q_item,
    output dip_pkg::back_stat_t stat,
    output logic          m_valid,
    input  wire logic     m_ready,
    output dip_pkg::dip_out_t m_result
);
    import dip_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_READ = 3'b010,
        PH_FAIL = 3'b100
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [VALUE_W-1:0]   acc_reg, acc_next;
    logic                 neg_reg, neg_next;
    logic                 any_reg, any_next;
    logic                 out_valid_reg, out_valid_next;
    dip_out_t             out_reg, out_next;

    logic                 advance;
    logic                 emit;
    logic [VALUE_W-1:0]   eff_acc;
    logic                 eff_neg;
    logic                 eff_any;
    logic [VALUE_W-1:0]   lim_base;
    logic [VALUE_W-1:0]   lim_sign;
    logic [VALUE_W:0]     lim;
    logic [VALUE_W+3:0]   cand;
    logic                 over;
    dip_out_t             finish_res;

    assign advance = q_valid & (~out_valid_reg | m_ready);

    // a token start discards whatever was pending
    assign eff_acc = q_item.token_start ? '0 : acc_reg;
    assign eff_neg = q_item.token_start ? 1'b0 : neg_reg;
    assign eff_any = q_item.token_start ? 1'b0 : any_reg;

    always_comb begin
        case (width_select)
            WIDTH_16: lim_base = {{(VALUE_W-16){1'b0}}, 16'hFFFF};
            WIDTH_32: lim_base = {{(VALUE_W-32){1'b0}}, 32'hFFFF_FFFF};
            default:  lim_base = '1;
        endcase
        lim_sign = signed_mode ? (lim_base >> 1) : lim_base;
        lim      = {1'b0, lim_sign} + {{VALUE_W{1'b0}}, eff_neg};
        cand     = ({4'b0, eff_acc} << 3) + ({4'b0, eff_acc} << 1)
                   + {{VALUE_W{1'b0}}, q_item.digit};
        over     = cand > {3'b0, lim};
    end

    always_comb begin
        if (!eff_any) begin
            finish_res.status = ST_DIGIT_EXPECTED;
            finish_res.value  = '0;
        end else begin
            finish_res.status = ST_OK;
            finish_res.value  = eff_neg ? (VALUE_W'(0) - eff_acc) : eff_acc;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        any_next   = any_reg;
        out_next   = out_reg;
        emit       = 1'b0;
        if (advance && (q_item.token_start || phase_reg == PH_READ)) begin
            phase_next = PH_READ;
            acc_next   = eff_acc;
            neg_next   = eff_neg;
            any_next   = eff_any;
            if (q_item.end_of_stream || !q_item.is_digit && !q_item.is_minus) begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
                out_next   = finish_res;
            end else if (q_item.is_minus) begin
                neg_next = 1'b1;
            end else begin
                any_next = 1'b1;
                if (over) begin
                    phase_next      = PH_FAIL;
                    emit            = 1'b1;
                    out_next.status = ST_OVERFLOW;
                    out_next.value  = '0;
                end else begin
                    acc_next = cand[VALUE_W-1:0];
                end
            end
        end
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign stat.pop  = advance;
    assign stat.emit = emit;
    assign m_valid   = out_valid_reg;
    assign m_result  = out_reg;

endmodule
`default_nettype wire

FILE: dv/decimal_integer_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_integer_parser_test
// Self-checking bench for the decimal integer parser. Characters go in one
// item at a time with random gaps. Results are drawn out under random back
// pressure. A parser model inside the bench keeps its own sign, width,
// accumulator and phase, and works out the value and status that each item
// should produce. Directed items cover terminators, token edges, the minus
// sign and the failed state. Random phases then sweep every sign and width
// setting with well-formed numbers, numbers at the overflow limit, broken
// tokens and noise.
// ----------------------------------------------------------------------------
module decimal_integer_parser_test;
    import dip_pkg::*;

    localparam int          CYCLE_LIMIT = 600000;
    // Undefined width code; the parser treats it as sixty-four bits
    localparam logic [1:0]  WIDTH_SPARE = 2'd3;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_DIGITS,
        SCAN_FAILED
    } scan_phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } parse_outcome_t;

    typedef logic [7:0] char_q_t[$];

    // ------------------------------------------------------------------
    // Clock, reset and the signals around the block
    // ------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    always #5 aclk = ~aclk;

    decimal_integer_parser uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] character
        .s_tuser   (s_tuser),    // [0] token_start
        .s_tlast   (s_tlast),    // end_of_stream
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [63:0] value, [65:64] status
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Parser model: configuration and scan state as the block holds them
    // after reset
    // ------------------------------------------------------------------
    logic          cfg_signed = 1'b0;
    logic [1:0]    cfg_width  = WIDTH_32;
    scan_phase_t   scan_phase = SCAN_IDLE;
    logic [63:0]   acc_mag    = '0;
    bit            minus_seen = 1'b0;
    bit            digit_seen = 1'b0;

    parse_outcome_t numbers_due[$];  // results owed by the block, oldest first
    int            error_count = 0;
    int            cycle_count = 0;
    bit            idle_off    = 1'b0;   // set for stretches with no gaps or stalls
    int            hold_left   = 0;

    // Largest magnitude allowed for the current setting; a minus adds one
    function automatic logic [63:0] magnitude_cap(input bit neg);
        logic [63:0] cap;
        case (cfg_width)
            WIDTH_16: cap = 64'hFFFF;
            WIDTH_32: cap = 64'hFFFF_FFFF;
            default:  cap = '1;
        endcase
        if (cfg_signed)
            cap = cap >> 1;
        if (neg)
            cap = cap + 64'd1;
        return cap;
    endfunction

    // Close the pending number; no digit at all means digit expected
    function automatic bit end_number(output parse_outcome_t res);
        scan_phase = SCAN_IDLE;
        if (!digit_seen) begin
            res.value  = '0;
            res.status = ST_DIGIT_EXPECTED;
        end else begin
            res.value  = minus_seen ? 64'd0 - acc_mag : acc_mag;
            res.status = ST_OK;
        end
        return 1'b1;
    endfunction

    // One character while digits are being read
    function automatic bit take_char(input logic [7:0] c, output parse_outcome_t res);
        logic [63:0] cap;
        logic [63:0] d;
        if (c < CHAR_ZERO || c > CHAR_NINE)
            return end_number(res);
        d          = 64'(c - CHAR_ZERO);
        digit_seen = 1'b1;
        cap        = magnitude_cap(minus_seen);
        if (acc_mag > cap / 64'd10 || d > cap - 64'd10 * acc_mag) begin
            scan_phase = SCAN_FAILED;
            res.value  = '0;
            res.status = ST_OVERFLOW;
            return 1'b1;
        end
        acc_mag = acc_mag * 64'd10 + d;
        return 1'b0;
    endfunction

    // Advance the model by one accepted item; returns 1 if a result is owed
    function automatic bit parse_char(input logic [7:0] c, input bit start, input bit eos,
                                      output parse_outcome_t res);
        res = '0;
        if (start) begin
            // A new token always drops whatever number was pending
            scan_phase = SCAN_DIGITS;
            acc_mag    = '0;
            minus_seen = 1'b0;
            digit_seen = 1'b0;
            if (eos)
                return end_number(res);
            if (cfg_signed && c == CHAR_MINUS) begin
                minus_seen = 1'b1;
                return 1'b0;
            end
            return take_char(c, res);
        end
        // Idle or failed: everything up to the next token start is ignored
        if (scan_phase != SCAN_DIGITS)
            return 1'b0;
        if (eos)
            return end_number(res);
        return take_char(c, res);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Mostly no gap, often a short one, now and then a long one
    function automatic int idle_span();
        int r;
        if (idle_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] any_non_digit();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c >= CHAR_ZERO && c <= CHAR_NINE);
        return c;
    endfunction

    function automatic char_q_t decimal_text(input logic [63:0] v);
        char_q_t text;
        if (v == 0)
            text.push_back(CHAR_ZERO);
        while (v != 0) begin
            text.push_front(CHAR_ZERO + 8'(v % 64'd10));
            v = v / 64'd10;
        end
        return text;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%016h, expected 0x%016h at %0t", what, got, want,
                 $realtime);
        error_count++;
    endtask

    // Present one item, hold it until it is taken, then maybe drop valid for a gap.
    // Valid stays high when no gap follows, so it is never lowered and raised in
    // the same step.
    task automatic send_char(input logic [7:0] c, input bit start, input bit eos);
        parse_outcome_t res;
        int             gap;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= start;
        s_tlast  <= eos;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (parse_char(c, start, eos, res))
            numbers_due.push_back(res);
        gap = idle_span();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop sending, wait for every owed result, then let items that owe
    // nothing clear the front queue and output register
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (numbers_due.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (idx == REG_SIGNED_MODE)
            cfg_signed = data[0];
        else
            cfg_width = data;
        cfg_valid <= 1'b0;
    endtask

    // One token of random shape: a number of random size, one near or past
    // the limit, or a broken one, then a terminator and perhaps some noise.
    // Returns the number of token items sent.
    task automatic send_random_token(output int sent);
        char_q_t     text;
        logic [63:0] mag;
        logic [63:0] cap;
        bit          neg;
        bit          starting;
        int          pick;
        sent = 0;
        neg  = cfg_signed && ($urandom_range(0, 1) == 1);
        cap  = magnitude_cap(neg);
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            mag = 64'($urandom_range(0, 9999));
        end else if (pick < 55) begin
            mag = {$urandom, $urandom} >> $urandom_range(0, 63);
            while (mag > cap)
                mag = mag >> 1;
        end else begin
            mag = cap - 64'($urandom_range(0, 12));
        end
        text = decimal_text(mag);
        // Try to push past the limit: change the last digit or add one more
        if (pick >= 85) begin
            if ($urandom_range(0, 1) == 1)
                text[text.size()-1] = CHAR_ZERO + 8'($urandom_range(0, 9));
            else
                text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) text.push_front(CHAR_ZERO);
        if ($urandom_range(0, 11) == 0)
            text.delete();
        // A minus in unsigned mode is just a non-digit
        if (!cfg_signed && $urandom_range(0, 19) == 0)
            neg = 1'b1;

        if (neg) begin
            send_char(CHAR_MINUS, 1'b1, 1'b0);
            sent++;
        end
        foreach (text[i]) begin
            send_char(text[i], !neg && i == 0, 1'b0);
            sent++;
        end

        // Terminator; with no item sent yet it must carry the token start
        starting = !neg && text.size() == 0;
        pick     = $urandom_range(0, 99);
        if (pick < 45) begin
            send_char(any_non_digit(), starting, 1'b0);
            sent++;
        end else if (pick < 75 || starting) begin
            send_char(8'($urandom_range(0, 255)), starting, 1'b1);
            sent++;
        end
        // otherwise leave it open: noise below or the next token start ends it

        // Noise after the token, the odd end of stream among it; ignored unless the token was left open
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4))
                send_char(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 7) == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Unsigned, thirty-two bits: numbers ended by the characters either side
    // of the digit range, a token of a non-digit, a minus that is not a sign
    task automatic test_terminators();
        send_char(CHAR_ZERO, 1'b1, 1'b0);
        send_char(CHAR_NINE + 8'd1, 1'b0, 1'b0);
        send_char(CHAR_NINE, 1'b1, 1'b0);
        send_char(CHAR_ZERO - 8'd1, 1'b0, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);
        send_char(8'h00, 1'b0, 1'b0);
        send_char(CHAR_MINUS, 1'b1, 1'b0);
    endtask

    // A token start while reading, end of stream while reading, with a token
    // start and while idle
    task automatic test_token_edges();
        send_char(CHAR_ZERO + 8'd1, 1'b1, 1'b0);
        send_char(CHAR_ZERO + 8'd2, 1'b1, 1'b0);
        send_char(8'hA5, 1'b0, 1'b1);
        send_char(8'h5A, 1'b1, 1'b1);
        send_char(8'h3C, 1'b0, 1'b1);
    endtask

    // Signed mode: negative zero, a minus with no digit, and a negative number
    // under the unused width code
    task automatic test_signed_minus();
        write_reg(REG_SIGNED_MODE, 2'b01);
        send_char(CHAR_MINUS, 1'b1, 1'b0);
        send_char(CHAR_ZERO, 1'b0, 1'b0);
        send_char(8'h00, 1'b0, 1'b1);
        send_char(CHAR_MINUS, 1'b1, 1'b0);
        send_char("x", 1'b0, 1'b0);
        send_char(CHAR_MINUS, 1'b1, 1'b0);
        send_char(8'h7F, 1'b0, 1'b1);
        write_reg(REG_WIDTH_SELECT, WIDTH_SPARE);
        send_char(CHAR_MINUS, 1'b1, 1'b0);
        send_char(CHAR_ZERO + 8'd7, 1'b0, 1'b0);
        send_char(CHAR_NINE + 8'd1, 1'b0, 1'b0);
    endtask

    // Unsigned sixteen bits: 65536 overflows on its last digit, then a digit
    // and an end of stream fall into the failed state and are ignored
    task automatic test_overflow_failed();
        write_reg(REG_SIGNED_MODE, 2'b00);
        write_reg(REG_WIDTH_SELECT, WIDTH_16);
        send_char(CHAR_ZERO + 8'd6, 1'b1, 1'b0);
        send_char(CHAR_ZERO + 8'd5, 1'b0, 1'b0);
        send_char(CHAR_ZERO + 8'd5, 1'b0, 1'b0);
        send_char(CHAR_ZERO + 8'd3, 1'b0, 1'b0);
        send_char(CHAR_ZERO + 8'd6, 1'b0, 1'b0);
        send_char(CHAR_ZERO + 8'd1, 1'b0, 1'b0);
        send_char(8'h20, 1'b0, 1'b1);
    endtask

    // Sixteen phases: first every sign and width code in turn, then random
    // settings. Each phase sends about sixty token items; some phases run
    // with no gaps and no stalls.
    task automatic test_random_phases();
        logic [1:0] width;
        bit         sgn;
        int         sent;
        int         n;
        for (int ph = 0; ph < 16; ph++) begin
            if (ph < 8) begin
                sgn   = ph[0];
                width = ph[2:1];
            end else begin
                sgn   = 1'($urandom_range(0, 1));
                width = 2'($urandom_range(0, 3));
            end
            // The upper data bit of the sign register is don't-care; set it at random
            write_reg(REG_SIGNED_MODE, {1'($urandom_range(0, 1)), sgn});
            write_reg(REG_WIDTH_SELECT, width);
            idle_off = ($urandom_range(0, 3) == 0);
            sent     = 0;
            while (sent < 60) begin
                send_random_token(n);
                sent += n;
            end
        end
        idle_off = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back pressure, long holds now and then
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        int span;
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            span = idle_span();
            if (span == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready  <= 1'b0;
                hold_left <= span - 1;
            end
        end
    end

    // Compare each taken result with the oldest one owed
    always @(posedge aclk) begin
        parse_outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (numbers_due.size() == 0) begin
                report_mismatch("result with none owed", m_tdata[63:0], '0);
            end else begin
                want = numbers_due.pop_front();
                if (m_tdata[63:0] !== want.value)
                    report_mismatch("value", m_tdata[63:0], want.value);
                if (m_tdata[65:64] !== want.status)
                    report_mismatch("status", 64'(m_tdata[65:64]), 64'(want.status));
            end
        end
    end

    // Guard against a hang
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("decimal_integer_parser verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_terminators();
        test_token_edges();
        test_signed_minus();
        test_overflow_failed();
        test_random_phases();
        wait_drained();
        if (error_count == 0)
            $display("decimal_integer_parser verification clean");
        else
            $display("decimal_integer_parser verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/dip_pkg.sv
src/dip_front.sv
src/dip_queue.sv
src/dip_back.sv
src/decimal_integer_parser.sv
dv/decimal_integer_parser_test.sv
